[hw/rtl/epoch_cleared_linear_probe_set_core_macros.svh]
// Assertion macros for the epoch-cleared linear probe set core.
// Used by the top level only; relies on i_clk and i_rst_n in scope.
`ifndef EPOCH_CLEARED_LINEAR_PROBE_SET_CORE_MACROS_SVH
`define EPOCH_CLEARED_LINEAR_PROBE_SET_CORE_MACROS_SVH

// same-cycle implication
`define ECLPS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("eclps: assertion failed");

// next-cycle implication
`define ECLPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("eclps: assertion failed");

`endif

[hw/rtl/eclps_pkg.sv]
// Shared types and constants of the epoch-cleared linear probe set core.
// No dependencies.
package eclps_pkg;

    localparam int KEY_W      = 64;
    localparam int COUNT_W    = 12;
    localparam int FOLD_SHIFT = 32;
    localparam int Q_DEPTH    = 2;

    localparam logic [COUNT_W-1:0] FILL_LIMIT_RESET = 12'd3072;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    localparam logic [1:0] ST_NEW     = 2'd0;
    localparam logic [1:0] ST_PRESENT = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_CLEARED = 2'd3;

    typedef struct packed {
        logic             operation;
        logic [KEY_W-1:0] key_high;
        logic [KEY_W-1:0] key_low;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]         status;
        logic [COUNT_W-1:0] entries_used;
    } t_out_beat;

    typedef struct packed {
        logic pop;
        logic sweep;
    } t_back_ctrl;

endpackage

[hw/rtl/eclps_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module eclps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[hw/rtl/eclps_front.sv]
// Front end: accepts input beats, computes the home slot, queues them for the back end.
// Depends on eclps_pkg.
module eclps_front #(
    parameter int TABLE_SLOTS = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  eclps_pkg::t_in_beat            i_in_data,
    input  eclps_pkg::t_back_ctrl          i_ctrl,
    output logic                           o_head_valid,
    output eclps_pkg::t_in_beat            o_head_beat,
    output logic [$clog2(TABLE_SLOTS)-1:0] o_head_home
);

    localparam int IDX_W = $clog2(TABLE_SLOTS);
    localparam int PTR_W = (eclps_pkg::Q_DEPTH > 1) ? $clog2(eclps_pkg::Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(eclps_pkg::Q_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(eclps_pkg::Q_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(eclps_pkg::Q_DEPTH);

    eclps_pkg::t_in_beat r_q_beat [eclps_pkg::Q_DEPTH];
    logic [IDX_W-1:0]    r_q_home [eclps_pkg::Q_DEPTH];
    logic [PTR_W-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                push;
    logic [eclps_pkg::KEY_W-1:0] fold;

    assign o_in_stall = (r_cnt == CNT_FULL) || i_ctrl.sweep;
    assign push       = i_in_valid && !o_in_stall;
    assign fold       = i_in_data.key_high ^ (i_in_data.key_low >> eclps_pkg::FOLD_SHIFT);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_ctrl.pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (push && !i_ctrl.pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (!push && i_ctrl.pop) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_beat[r_wr_ptr] <= i_in_data;
            r_q_home[r_wr_ptr] <= fold[IDX_W-1:0];
        end
    end

    assign o_head_valid = (r_cnt != '0);
    assign o_head_beat  = r_q_beat[r_rd_ptr];
    assign o_head_home  = r_q_home[r_rd_ptr];

endmodule

[hw/rtl/eclps_back.sv]
// Back end: probe engine over the key and tag tables, epoch and count, result register.
// Depends on eclps_pkg and eclps_ram.
module eclps_back #(
    parameter int TABLE_SLOTS = 4096,
    parameter int EPOCH_BITS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [eclps_pkg::COUNT_W-1:0]       i_fill_limit,
    input  logic                                i_head_valid,
    input  eclps_pkg::t_in_beat                 i_head_beat,
    input  logic [$clog2(TABLE_SLOTS)-1:0]      i_head_home,
    output eclps_pkg::t_back_ctrl               o_ctrl,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output eclps_pkg::t_out_beat                o_out_data
);

    localparam int IDX_W = $clog2(TABLE_SLOTS);
    localparam int KEY2_W = 2 * eclps_pkg::KEY_W;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_SLOTS - 1);

    localparam logic [1:0] S_SWEEP = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_PROBE = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]                    r_state, n_state;
    logic [IDX_W-1:0]              r_idx, n_idx;
    logic [IDX_W-1:0]              r_visited, n_visited;
    logic [EPOCH_BITS-1:0]         r_epoch, n_epoch;
    logic [eclps_pkg::COUNT_W-1:0] r_count, n_count;
    logic                          r_wrap, n_wrap;
    logic [1:0]                    r_res, n_res;
    logic [KEY2_W-1:0]             r_key, n_key;
    logic                          r_out_valid, n_out_valid;
    eclps_pkg::t_out_beat          r_out_data, n_out_data;

    logic [EPOCH_BITS-1:0] epoch_inc;
    logic                  tag_we, key_we, pop;
    logic [IDX_W-1:0]      rd_addr;
    logic [EPOCH_BITS-1:0] tag_wdata, tag_rd;
    logic [KEY2_W-1:0]     key_rd;
    logic                  live, match;

    eclps_ram #(.WIDTH(EPOCH_BITS), .DEPTH(TABLE_SLOTS)) u_tag_ram (
        .i_clk     (i_clk),
        .i_wr_en   (tag_we),
        .i_wr_addr (r_idx),
        .i_wr_data (tag_wdata),
        .i_rd_addr (rd_addr),
        .o_rd_data (tag_rd)
    );

    eclps_ram #(.WIDTH(KEY2_W), .DEPTH(TABLE_SLOTS)) u_key_ram (
        .i_clk     (i_clk),
        .i_wr_en   (key_we),
        .i_wr_addr (r_idx),
        .i_wr_data (r_key),
        .i_rd_addr (rd_addr),
        .o_rd_data (key_rd)
    );

    assign epoch_inc = r_epoch + EPOCH_BITS'(1);
    assign live      = (tag_rd == r_epoch);
    assign match     = (key_rd == r_key);

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_visited   = r_visited;
        n_epoch     = r_epoch;
        n_count     = r_count;
        n_wrap      = r_wrap;
        n_res       = r_res;
        n_key       = r_key;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        tag_we      = 1'b0;
        key_we      = 1'b0;
        tag_wdata   = r_epoch;
        rd_addr     = r_idx;
        pop         = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_SWEEP: begin
                tag_we    = 1'b1;
                tag_wdata = '0;
                if (r_idx == IDX_LAST) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_IDLE: begin
                rd_addr = i_head_home;
                if (i_head_valid) begin
                    pop   = 1'b1;
                    n_key = {i_head_beat.key_high, i_head_beat.key_low};
                    if (i_head_beat.operation == eclps_pkg::OP_CLEAR) begin
                        n_count = '0;
                        n_res   = eclps_pkg::ST_CLEARED;
                        n_state = S_DONE;
                        if (epoch_inc == '0) begin
                            n_epoch = EPOCH_BITS'(1);
                            n_wrap  = 1'b1;
                        end else begin
                            n_epoch = epoch_inc;
                        end
                    end else begin
                        n_idx     = i_head_home;
                        n_visited = '0;
                        n_state   = S_PROBE;
                    end
                end
            end
            S_PROBE: begin
                if (live) begin
                    if (match) begin
                        n_res   = eclps_pkg::ST_PRESENT;
                        n_state = S_DONE;
                    end else if (r_visited == IDX_LAST) begin
                        n_res   = eclps_pkg::ST_FULL;
                        n_state = S_DONE;
                    end else begin
                        n_visited = r_visited + IDX_W'(1);
                        n_idx     = r_idx + IDX_W'(1);
                        rd_addr   = r_idx + IDX_W'(1);
                    end
                end else if (r_count >= i_fill_limit) begin
                    n_res   = eclps_pkg::ST_FULL;
                    n_state = S_DONE;
                end else begin
                    tag_we  = 1'b1;
                    key_we  = 1'b1;
                    n_count = r_count + eclps_pkg::COUNT_W'(1);
                    n_res   = eclps_pkg::ST_NEW;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid             = 1'b1;
                    n_out_data.status       = r_res;
                    n_out_data.entries_used = r_count;
                    n_wrap                  = 1'b0;
                    if (r_wrap) begin
                        n_idx   = '0;
                        n_state = S_SWEEP;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_idx       <= '0;
            r_visited   <= '0;
            r_epoch     <= EPOCH_BITS'(1);
            r_count     <= '0;
            r_wrap      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_visited   <= n_visited;
            r_epoch     <= n_epoch;
            r_count     <= n_count;
            r_wrap      <= n_wrap;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res      <= n_res;
        r_key      <= n_key;
        r_out_data <= n_out_data;
    end

    assign o_ctrl.pop   = pop;
    assign o_ctrl.sweep = (r_state == S_SWEEP);
    assign o_out_valid  = r_out_valid;
    assign o_out_data   = r_out_data;

endmodule

[hw/rtl/epoch_cleared_linear_probe_set_core.sv]
// Top level of the epoch-cleared linear probe set core.
// Depends on eclps_pkg, eclps_front, eclps_back and the macros header.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data): one beat per insert or clear.
//   Output channel (o_out_valid / i_out_stall / o_out_data): exactly one result beat
//   per input beat, in order: status and the live entry count after the item.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data): writes the fill limit;
//   always ready, write only while no item is outstanding.
// Timing:
//   An insert reads slots one after another from its home slot until it finds its key,
//   a free slot or a full table, and holds the back end as long; a clear reads no slot. A two-beat
//   queue takes new beats while the back end probes one RAM slot per cycle.
// Reset:
//   Epoch is 1, count 0, fill limit 3072. The tag RAM is then swept to zero, one slot
//   a cycle, over all TABLE_SLOTS slots with o_in_stall high; a clear whose epoch advance
//   wraps to zero runs the same sweep.
// Stalls:
//   A stalled result holds the output register; one more item finishes behind it and
//   the queue fills before o_in_stall rises.
`include "epoch_cleared_linear_probe_set_core_macros.svh"

module epoch_cleared_linear_probe_set_core #(
    parameter int TABLE_SLOTS = 4096,
    parameter int EPOCH_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  eclps_pkg::t_in_beat           i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output eclps_pkg::t_out_beat          o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [eclps_pkg::COUNT_W-1:0] i_cfg_data
);

    localparam int IDX_W = $clog2(TABLE_SLOTS);
    localparam logic [eclps_pkg::COUNT_W-1:0] USED_ONE = eclps_pkg::COUNT_W'(1);

    logic [eclps_pkg::COUNT_W-1:0] r_fill_limit, n_fill_limit;
    eclps_pkg::t_back_ctrl         ctrl;
    logic                          head_valid;
    eclps_pkg::t_in_beat           head_beat;
    logic [IDX_W-1:0]              head_home;
    logic                          res_clear;
    logic                          res_new;
    logic                          clear_fire;
    logic [eclps_pkg::COUNT_W-1:0] res_used;

    assign o_cfg_ready  = 1'b1;
    assign n_fill_limit = (i_cfg_valid && o_cfg_ready) ? i_cfg_data : r_fill_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_limit <= eclps_pkg::FILL_LIMIT_RESET;
        end else begin
            r_fill_limit <= n_fill_limit;
        end
    end

    eclps_front #(.TABLE_SLOTS(TABLE_SLOTS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_ctrl       (ctrl),
        .o_head_valid (head_valid),
        .o_head_beat  (head_beat),
        .o_head_home  (head_home)
    );

    eclps_back #(.TABLE_SLOTS(TABLE_SLOTS), .EPOCH_BITS(EPOCH_BITS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fill_limit (r_fill_limit),
        .i_head_valid (head_valid),
        .i_head_beat  (head_beat),
        .i_head_home  (head_home),
        .o_ctrl       (ctrl),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_data   (o_out_data)
    );

    assign res_clear  = o_out_valid && (o_out_data.status == eclps_pkg::ST_CLEARED);
    assign res_new    = o_out_valid && (o_out_data.status == eclps_pkg::ST_NEW);
    assign clear_fire = res_clear && !i_out_stall;
    assign res_used   = o_out_data.entries_used;

    `ECLPS_ASSERT_NOW(a_cleared_is_empty, res_clear, res_used == '0)
    `ECLPS_ASSERT_NOW(a_new_within_limit, res_new, res_used != '0 && res_used <= r_fill_limit)
    `ECLPS_ASSERT_NEXT(a_first_after_clear, clear_fire, !res_new || res_used == USED_ONE)

endmodule

[bench/probe_set_checker.sv]
// Result checker for the epoch-cleared linear probe set core: keeps a shadow copy of the
// slot table, epoch, live count and fill limit, predicts every result beat, compares it.
// Depends on eclps_pkg.
module probe_set_checker #(
    parameter int TABLE_SLOTS = 16,
    parameter int EPOCH_BITS  = 2
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  eclps_pkg::t_in_beat           i_in_data,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  eclps_pkg::t_out_beat          i_out_data,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [eclps_pkg::COUNT_W-1:0] i_cfg_data,
    output int                            o_mismatch_count,
    output int                            o_pending
);

    logic [eclps_pkg::KEY_W-1:0]   shadow_key_high [TABLE_SLOTS];
    logic [eclps_pkg::KEY_W-1:0]   shadow_key_low  [TABLE_SLOTS];
    logic [EPOCH_BITS-1:0]         shadow_tag      [TABLE_SLOTS];
    logic [EPOCH_BITS-1:0]         shadow_epoch;
    logic [eclps_pkg::COUNT_W-1:0] shadow_used;
    logic [eclps_pkg::COUNT_W-1:0] shadow_fill_limit;
    eclps_pkg::t_out_beat          expected_results [$];

    function automatic eclps_pkg::t_out_beat predict_result(input eclps_pkg::t_in_beat beat);
        logic [eclps_pkg::KEY_W-1:0] fold;
        int unsigned                 slot;
        int unsigned                 visited;
        logic [1:0]                  status;
        bit                          settled;
        eclps_pkg::t_out_beat        res;
        if (beat.operation == eclps_pkg::OP_CLEAR) begin
            shadow_used  = '0;
            shadow_epoch = shadow_epoch + 1'b1;
            if (shadow_epoch == '0) begin
                foreach (shadow_tag[i]) shadow_tag[i] = '0;
                shadow_epoch = EPOCH_BITS'(1);
            end
            status = eclps_pkg::ST_CLEARED;
        end else begin
            fold    = beat.key_high ^ (beat.key_low >> eclps_pkg::FOLD_SHIFT);
            slot    = int'(fold % TABLE_SLOTS);
            visited = 0;
            settled = 1'b0;
            status  = eclps_pkg::ST_NEW;
            while (!settled && shadow_tag[slot] == shadow_epoch) begin
                if (shadow_key_high[slot] == beat.key_high &&
                    shadow_key_low[slot] == beat.key_low) begin
                    status  = eclps_pkg::ST_PRESENT;
                    settled = 1'b1;
                end else begin
                    visited++;
                    if (visited >= TABLE_SLOTS) begin
                        status  = eclps_pkg::ST_FULL;
                        settled = 1'b1;
                    end else begin
                        slot = (slot + 1) % TABLE_SLOTS;
                    end
                end
            end
            if (!settled) begin
                if (shadow_used >= shadow_fill_limit) begin
                    status = eclps_pkg::ST_FULL;
                end else begin
                    shadow_key_high[slot] = beat.key_high;
                    shadow_key_low[slot]  = beat.key_low;
                    shadow_tag[slot]      = shadow_epoch;
                    shadow_used           = shadow_used + 1'b1;
                end
            end
        end
        res.status       = status;
        res.entries_used = shadow_used;
        return res;
    endfunction

    always @(posedge i_clk) begin : monitor
        eclps_pkg::t_out_beat want;
        eclps_pkg::t_out_beat fresh;
        int                   errs;
        errs = 0;
        if (!i_rst_n) begin
            foreach (shadow_tag[i]) begin
                shadow_tag[i]      = '0;
                shadow_key_high[i] = '0;
                shadow_key_low[i]  = '0;
            end
            shadow_epoch      = EPOCH_BITS'(1);
            shadow_used       = '0;
            shadow_fill_limit = eclps_pkg::FILL_LIMIT_RESET;
            expected_results.delete();
            o_mismatch_count <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                shadow_fill_limit = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                fresh = predict_result(i_in_data);
                expected_results.insert(expected_results.size(), fresh);
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result beat status %0d entries %0d", $time,
                             i_out_data.status, i_out_data.entries_used);
                    errs++;
                end else begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    if (i_out_data.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.status, i_out_data.status);
                        errs++;
                    end
                    if (i_out_data.entries_used !== want.entries_used) begin
                        $display("%0t: entries_used expected %0d actual %0d", $time,
                                 want.entries_used, i_out_data.entries_used);
                        errs++;
                    end
                end
            end
            o_mismatch_count <= o_mismatch_count + errs;
        end
        o_pending <= expected_results.size();
    end

endmodule

[bench/testbench.sv]
// Top of the probe set bench: drives inserts, clears and fill-limit writes under random
// back-pressure into the core and reports the verdict from probe_set_checker.
// Depends on eclps_pkg, epoch_cleared_linear_probe_set_core and probe_set_checker.
module testbench;

    localparam int TABLE_SLOTS  = 4096;
    localparam int EPOCH_BITS   = 16;
    localparam int DRAIN_CYCLES = TABLE_SLOTS + 16;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          in_valid  = 1'b0;
    logic                          in_stall;
    eclps_pkg::t_in_beat           in_data   = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    eclps_pkg::t_out_beat          out_data;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [eclps_pkg::COUNT_W-1:0] cfg_data  = '0;

    int                              tx_idle_pct = 27;
    int                              rx_idle_pct = 45;
    int                              mismatch_count;
    int                              pending;
    logic [2*eclps_pkg::KEY_W-1:0]   key_pool [$];

    epoch_cleared_linear_probe_set_core #(
        .TABLE_SLOTS(TABLE_SLOTS),
        .EPOCH_BITS (EPOCH_BITS)
    ) u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data)
    );

    probe_set_checker #(
        .TABLE_SLOTS(TABLE_SLOTS),
        .EPOCH_BITS (EPOCH_BITS)
    ) u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_in_data       (in_data),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_out_data      (out_data),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .o_mismatch_count(mismatch_count),
        .o_pending       (pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    task automatic send_beat(input logic op, input logic [eclps_pkg::KEY_W-1:0] hi,
                             input logic [eclps_pkg::KEY_W-1:0] lo);
        in_valid <= 1'b1;
        in_data  <= '{operation: op, key_high: hi, key_low: lo};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < tx_idle_pct) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_fill_limit(input logic [eclps_pkg::COUNT_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [eclps_pkg::KEY_W-1:0] random_half();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_random(input int count, input int clear_pct);
        logic [2*eclps_pkg::KEY_W-1:0] key;
        int                            pick;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < clear_pct) begin
                send_beat(eclps_pkg::OP_CLEAR, {$urandom, $urandom}, {$urandom, $urandom});
            end else begin
                if (pick < 45 && key_pool.size() != 0) begin
                    key = key_pool[$urandom_range(key_pool.size() - 1)];
                end else begin
                    key = {random_half(), random_half()};
                    key_pool.insert(key_pool.size(), key);
                    if (key_pool.size() > 48) key_pool.delete(0);
                end
                send_beat(eclps_pkg::OP_INSERT, key[2*eclps_pkg::KEY_W-1:eclps_pkg::KEY_W],
                          key[eclps_pkg::KEY_W-1:0]);
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // probe chains, wrap at the table end, duplicates, then repeated clears
        send_beat(eclps_pkg::OP_INSERT, 64'h0, 64'h0);
        send_beat(eclps_pkg::OP_INSERT, 64'h0, 64'h0);
        send_beat(eclps_pkg::OP_INSERT, '1, '1);
        send_beat(eclps_pkg::OP_INSERT, '1, '1);
        send_beat(eclps_pkg::OP_INSERT, 64'h0, 64'h0000_0001_0000_0000);
        send_beat(eclps_pkg::OP_INSERT, 64'd4095, 64'h0);
        send_beat(eclps_pkg::OP_INSERT, 64'd8191, 64'h0);
        send_beat(eclps_pkg::OP_INSERT, 64'd8191, 64'h0);
        send_beat(eclps_pkg::OP_INSERT, 64'h8000_0000_0000_0000, 64'h0000_0001_0000_0000);
        send_beat(eclps_pkg::OP_INSERT, 64'h0, 64'hFFFF_FFFF_0000_0000);
        send_beat(eclps_pkg::OP_CLEAR, '1, '1);
        send_beat(eclps_pkg::OP_INSERT, 64'h0, 64'h0);
        send_beat(eclps_pkg::OP_INSERT, '1, '1);
        repeat (7) send_beat(eclps_pkg::OP_CLEAR, {$urandom, $urandom}, {$urandom, $urandom});
        send_beat(eclps_pkg::OP_INSERT, 64'h0, 64'h0);
        send_beat(eclps_pkg::OP_INSERT, 64'h0, 64'h0);

        send_random(200, 2);
        write_fill_limit('0);
        send_random(40, 3);

        tx_idle_pct = 45;
        rx_idle_pct = 27;
        write_fill_limit(12'd1);
        send_random(60, 4);
        write_fill_limit('1);
        send_random(150, 1);
        write_fill_limit(eclps_pkg::COUNT_W'($urandom_range(2, 40)));
        send_random(150, 3);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_fill_limit(12'd20);
        send_random(130, 3);

        wait_drained();
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
